FILE: hdl/tfts_pkg.sv
`default_nettype none

package tfts_pkg;

    // Default sizes of the two tables
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int TIMER_SLOTS_DEF = 10;

    // Request actions
    localparam logic [1:0] ACT_SCHEDULE = 2'd0;
    localparam logic [1:0] ACT_DISPATCH = 2'd1;
    localparam logic [1:0] ACT_PURGE    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SLOT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Request payload
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  task_id;
        logic [63:0] task_data;
        logic [15:0] timer_ticks;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [1:0]  status;
        logic        out_valid;
        logic [7:0]  out_task_id;
        logic [63:0] out_task_data;
        logic [4:0]  pending_count;
    } t_res;

endpackage

`default_nettype wire

FILE: hdl/task_fifo_and_timer_slot_table_core.sv
// Sequence from accept to result register load: schedule, unused action and empty
//   dispatch load from S_EXEC; dispatch reads the FIFO, then loads from S_READ; purge
//   walks both tables in S_WALK, then loads from S_TAIL. Result loads wait on output
//   stalls; one request in flight, dispatch waits on the read.
// Reset: synchronous, active low; clears indexes, count, slot busy bits and handshake
//   state. FIFO and slot id memories are not cleared.
`default_nettype none

module task_fifo_and_timer_slot_table_core
    import tfts_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_stall,
    input  wire t_req i_req_data,
    output logic      o_res_valid,
    input  wire logic i_res_stall,
    output t_res      o_res_data
);

    localparam int IDX_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH);
    localparam int SLOT_W   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int WALK_LEN = (QUEUE_DEPTH > TIMER_SLOTS) ? QUEUE_DEPTH : TIMER_SLOTS;
    localparam int WALK_W   = $clog2(WALK_LEN);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_TAIL = 3'd4;

    // Control state
    logic [2:0]             r_state, n_state;
    logic [IDX_W-1:0]       r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]       r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [TIMER_SLOTS-1:0] r_slot_busy;
    logic [WALK_W-1:0]      r_walk_idx;
    logic                   r_walk_fifo_en;
    logic                   r_wk_fifo_v;
    logic                   r_wk_slot_v;
    logic [WALK_W-1:0]      r_wk_idx;
    logic                   r_res_valid;
    t_req                   r_req;
    t_res                   r_res, n_res;

    // Memories and their registered read data
    logic [7:0]  fifo_ids   [QUEUE_DEPTH];
    logic [63:0] fifo_words [QUEUE_DEPTH];
    logic [7:0]  slot_ids   [TIMER_SLOTS];
    logic [7:0]  r_fifo_rd_id;
    logic [63:0] r_fifo_rd_word;
    logic [7:0]  r_slot_rd_id;

    logic              out_free;
    logic              res_load;
    logic              sched_fifo_we;
    logic              sched_slot_we;
    logic              disp_re;
    logic              walk_fifo_re;
    logic              walk_slot_re;
    logic              walk_start;
    logic              fifo_clr;
    logic              slot_clr;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              ids_we;
    logic [IDX_W-1:0]  ids_waddr;
    logic [7:0]        ids_wdata;
    logic              fifo_re;
    logic [IDX_W-1:0]  fifo_raddr;
    logic [IDX_W-1:0]  wr_idx_inc;
    logic [IDX_W-1:0]  rd_idx_inc;

    assign out_free    = !r_res_valid || !i_res_stall;
    assign o_req_stall = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res;

    assign wr_idx_inc = (r_wr_idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_idx + IDX_W'(1);
    assign rd_idx_inc = (r_rd_idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_idx + IDX_W'(1);

    // Lowest free timer slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = TIMER_SLOTS - 1; s >= 0; s--) begin
            if (!r_slot_busy[s]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(s);
            end
        end
    end

    // Purge compare stage: acts on the registered read data from the read stage
    always_comb begin
        fifo_clr = 1'b0;
        slot_clr = 1'b0;
        if (r_state == S_WALK || r_state == S_TAIL) begin
            fifo_clr = r_wk_fifo_v && (r_fifo_rd_id == r_req.task_id);
            slot_clr = r_wk_slot_v && r_slot_busy[r_wk_idx[SLOT_W-1:0]]
                       && (r_slot_rd_id == r_req.task_id);
        end
    end

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_wr_idx      = r_wr_idx;
        n_rd_idx      = r_rd_idx;
        n_count       = r_count;
        sched_fifo_we = 1'b0;
        sched_slot_we = 1'b0;
        disp_re       = 1'b0;
        walk_fifo_re  = 1'b0;
        walk_slot_re  = 1'b0;
        walk_start    = 1'b0;
        res_load      = 1'b0;
        n_res         = '0;
        n_res.status  = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_req.action)
                    ACT_SCHEDULE: begin
                        if (out_free) begin
                            res_load = 1'b1;
                            n_state  = S_IDLE;
                            if (r_req.timer_ticks != 16'd0) begin
                                if (free_found) begin
                                    sched_slot_we = 1'b1;
                                end else begin
                                    n_res.status = ST_NO_SLOT;
                                end
                            end else if (r_count >= CNT_W'(QUEUE_DEPTH - 1)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                sched_fifo_we = 1'b1;
                                n_wr_idx      = wr_idx_inc;
                                n_count       = r_count + CNT_W'(1);
                            end
                        end
                    end
                    ACT_DISPATCH: begin
                        if (r_count != '0) begin
                            disp_re  = 1'b1;
                            n_rd_idx = rd_idx_inc;
                            n_count  = r_count - CNT_W'(1);
                            n_state  = S_READ;
                        end else if (out_free) begin
                            res_load = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    ACT_PURGE: begin
                        walk_start = 1'b1;
                        n_state    = S_WALK;
                    end
                    default: begin
                        if (out_free) begin
                            res_load = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                endcase
            end
            S_READ: begin
                if (out_free) begin
                    res_load            = 1'b1;
                    n_res.out_valid     = 1'b1;
                    n_res.out_task_id   = r_fifo_rd_id;
                    n_res.out_task_data = r_fifo_rd_word;
                    n_state             = S_IDLE;
                end
            end
            S_WALK: begin
                walk_fifo_re = r_walk_fifo_en && (32'(r_walk_idx) < QUEUE_DEPTH);
                walk_slot_re = (32'(r_walk_idx) < TIMER_SLOTS);
                if (r_walk_idx == WALK_W'(WALK_LEN - 1)) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    res_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_res.pending_count = 5'(n_count);
    end

    // FIFO id memory port muxing
    assign ids_we     = sched_fifo_we || fifo_clr;
    assign ids_waddr  = fifo_clr ? r_wk_idx[IDX_W-1:0] : r_wr_idx;
    assign ids_wdata  = fifo_clr ? 8'd0 : r_req.task_id;
    assign fifo_re    = disp_re || walk_fifo_re;
    assign fifo_raddr = walk_fifo_re ? r_walk_idx[IDX_W-1:0] : r_rd_idx;

    // FIFO memories
    always_ff @(posedge i_clk) begin
        if (ids_we) begin
            fifo_ids[ids_waddr] <= ids_wdata;
        end
        if (fifo_re) begin
            r_fifo_rd_id <= fifo_ids[fifo_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sched_fifo_we) begin
            fifo_words[r_wr_idx] <= r_req.task_data;
        end
        if (disp_re) begin
            r_fifo_rd_word <= fifo_words[r_rd_idx];
        end
    end

    // Slot id memory; only the id is read back, by the purge walk
    always_ff @(posedge i_clk) begin
        if (sched_slot_we) begin
            slot_ids[free_idx] <= r_req.task_id;
        end
        if (walk_slot_re) begin
            r_slot_rd_id <= slot_ids[r_walk_idx[SLOT_W-1:0]];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_req_valid && !o_req_stall) begin
            r_req <= i_req_data;
        end
        if (res_load) begin
            r_res <= n_res;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_wr_idx       <= '0;
            r_rd_idx       <= '0;
            r_count        <= '0;
            r_slot_busy    <= '0;
            r_walk_idx     <= '0;
            r_walk_fifo_en <= 1'b0;
            r_wk_fifo_v    <= 1'b0;
            r_wk_slot_v    <= 1'b0;
            r_wk_idx       <= '0;
            r_res_valid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;

            // slot busy bits: set on timer schedule, cleared on purge match
            if (sched_slot_we) begin
                r_slot_busy[free_idx] <= 1'b1;
            end
            if (slot_clr) begin
                r_slot_busy[r_wk_idx[SLOT_W-1:0]] <= 1'b0;
            end

            // purge walk: read stage then compare stage
            if (walk_start) begin
                r_walk_idx     <= '0;
                r_walk_fifo_en <= (r_count != '0);
                r_wk_fifo_v    <= 1'b0;
                r_wk_slot_v    <= 1'b0;
            end else if (r_state == S_WALK) begin
                r_walk_idx  <= r_walk_idx + WALK_W'(1);
                r_wk_fifo_v <= walk_fifo_re;
                r_wk_slot_v <= walk_slot_re;
                r_wk_idx    <= r_walk_idx;
            end

            // result register
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Count never reaches the queue depth
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= QUEUE_DEPTH - 1)
        else $error("FIFO count above limit");

    // Write index stays read index plus count, modulo the depth
    a_index_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_idx == IDX_W'(((32'(r_rd_idx) + 32'(r_count)) >= QUEUE_DEPTH)
                    ? (32'(r_rd_idx) + 32'(r_count) - QUEUE_DEPTH)
                    : (32'(r_rd_idx) + 32'(r_count))))
        else $error("FIFO indexes and count disagree");

    // A new result only comes from a finishing state
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> (r_state == S_EXEC || r_state == S_READ || r_state == S_TAIL))
        else $error("result loaded outside a finishing state");

    // A dispatched result always follows a memory read; it may then wait on the output
    a_disp_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ($past(disp_re) || $past(r_state) == S_READ))
        else $error("dispatch result without a read");

endmodule

`default_nettype wire
